// ===== rtl/rfpt_pkg.sv =====
// rfpt_pkg: types and constants for the ring FIFO with peak tracking.
// Holds the request/response beat layouts and the controller/datapath links.
// No dependencies.
package rfpt_pkg;

	// fixed field widths of the request and response beats
	localparam int CNT_W  = 7;
	localparam int WORD_W = 8;

	// request command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] write_word;
		logic              batch_end;
		logic [CNT_W-1:0]  read_count;
	} req_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_word;
		logic              valid_res;
		logic [CNT_W-1:0]  done_count;
		logic [CNT_W-1:0]  occupancy;
		logic [CNT_W-1:0]  peak;
		logic              last;
	} rsp_item_t;

	// controller -> datapath commands (at most one set per cycle)
	typedef struct packed {
		logic do_write;  // accepted write beat
		logic do_start;  // accepted read beat with a nonzero run
		logic do_empty;  // accepted read beat that moves nothing
		logic do_word;   // emit one word of the current run
	} ctl_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic space;      // response stage can take a result
		logic clip_zero;  // clipped run length of the request is zero
		logic run_last;   // next word is the final one of the run
	} dp_stat_t;

endpackage

// ===== rtl/rfpt_ifs.sv =====
// Channel interfaces for the ring FIFO with peak tracking.
// Request, response and configuration channels; depends on rfpt_pkg.
interface rfpt_req_if;
	import rfpt_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rfpt_rsp_if;
	import rfpt_pkg::*;
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rfpt_cfg_if;
	import rfpt_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rfpt_ctrl.sv =====
// rfpt_ctrl: sequencing state machine for the ring FIFO.
// Takes request beats, issues datapath commands; depends on rfpt_pkg.
module rfpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_cmd,
	output logic              req_ready,
	input  rfpt_pkg::dp_stat_t stat,
	output rfpt_pkg::ctl_cmd_t cmd
);
	import rfpt_pkg::*;

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_RUN  = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       accept;

	assign req_ready = (state_q == ST_IDLE) && stat.space;
	assign accept    = req_valid && req_ready;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_cmd == CMD_WRITE) begin
						cmd.do_write = 1'b1;
					end else if (stat.clip_zero) begin
						cmd.do_empty = 1'b1;
					end else begin
						cmd.do_start = 1'b1;
						state_d      = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (stat.space) begin
					cmd.do_word = 1'b1;
					if (stat.run_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== rtl/rfpt_dp.sv =====
// rfpt_dp: datapath of the ring FIFO: word memory, pointers, counters,
// configured depth and the two-entry response stage. Depends on rfpt_pkg.
module rfpt_dp #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 8,
	parameter int MAX_BURST = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rfpt_pkg::req_item_t        req_data,
	input  logic                       cfg_we,
	input  logic [rfpt_pkg::CNT_W-1:0] cfg_data,
	input  rfpt_pkg::ctl_cmd_t         cmd,
	output rfpt_pkg::dp_stat_t         stat,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output rfpt_pkg::rsp_item_t        rsp_data
);
	import rfpt_pkg::*;

	// the 7-bit depth register cannot address more than 127 entries
	localparam int USE_DEPTH = (DEPTH < 127) ? DEPTH : 127;
	localparam int ADDR_W    = $clog2(USE_DEPTH);
	localparam int RST_DEPTH = (USE_DEPTH < 64) ? USE_DEPTH : 64;
	// result bits below the read word
	localparam int TAIL_W    = $bits(rsp_item_t) - WORD_W;

	logic [WORD_BITS-1:0] mem [USE_DEPTH];

	logic [CNT_W-1:0]  depth_q;
	logic [ADDR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  fill_q, peak_q, batch_q;
	logic [CNT_W-1:0]  run_len_q, run_cnt_q;
	logic              out_v_q, skid_v_q;
	rsp_item_t         out_q, skid_q;

	logic [CNT_W-1:0]  cfg_depth;
	logic [CNT_W-1:0]  clip_a, clip_n;
	logic              full;
	logic [CNT_W:0]    wr_inc, rd_inc;
	logic [ADDR_W-1:0] wr_ptr_nx, rd_ptr_nx;
	logic [CNT_W-1:0]  fill_up, fill_dn, batch_up, run_cnt_up;
	logic              wr_ok;
	logic              emit, pop, out_free;
	logic              load_out, load_skid;
	rsp_item_t         res;

	// clamp a written depth into 1..USE_DEPTH
	always_comb begin
		if (cfg_data == '0)                     cfg_depth = CNT_W'(1);
		else if (32'(cfg_data) > USE_DEPTH)     cfg_depth = CNT_W'(USE_DEPTH);
		else                                    cfg_depth = cfg_data;
	end

	// run length: request clipped to occupancy and largest burst
	always_comb begin
		clip_a = (req_data.read_count > fill_q) ? fill_q : req_data.read_count;
		clip_n = (clip_a > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : clip_a;
	end

	// pointer wrap at the configured depth
	assign wr_inc    = (CNT_W+1)'(wr_ptr_q) + 1'b1;
	assign rd_inc    = (CNT_W+1)'(rd_ptr_q) + 1'b1;
	assign wr_ptr_nx = (wr_inc >= {1'b0, depth_q}) ? '0 : ADDR_W'(wr_inc);
	assign rd_ptr_nx = (rd_inc >= {1'b0, depth_q}) ? '0 : ADDR_W'(rd_inc);

	assign full       = (fill_q >= depth_q);
	assign wr_ok      = cmd.do_write && !full;
	assign fill_up    = fill_q + 1'b1;
	assign fill_dn    = fill_q - 1'b1;
	assign batch_up   = (batch_q == '1) ? batch_q : batch_q + 1'b1;
	assign run_cnt_up = run_cnt_q + 1'b1;

	assign stat.space     = !skid_v_q;
	assign stat.clip_zero = (clip_n == '0);
	assign stat.run_last  = (run_cnt_up == run_len_q);

	// result fields other than the memory word
	always_comb begin
		res           = '0;
		res.occupancy = fill_q;
		res.peak      = peak_q;
		if (cmd.do_write) begin
			res.valid_res  = !full;
			res.done_count = full ? batch_q : batch_up;
			res.last       = req_data.batch_end;
			if (!full) begin
				res.occupancy = fill_up;
				res.peak      = (fill_up > peak_q) ? fill_up : peak_q;
			end
		end else if (cmd.do_word) begin
			res.valid_res  = 1'b1;
			res.done_count = run_cnt_up;
			res.occupancy  = fill_dn;
			res.last       = stat.run_last;
		end else begin
			res.last = 1'b1;
		end
	end

	// queue state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= CNT_W'(RST_DEPTH);
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			peak_q    <= '0;
			batch_q   <= '0;
			run_len_q <= '0;
			run_cnt_q <= '0;
		end else if (cfg_we) begin
			depth_q  <= cfg_depth;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			peak_q   <= '0;
			batch_q  <= '0;
		end else begin
			if (cmd.do_write) begin
				if (!full) begin
					wr_ptr_q <= wr_ptr_nx;
					fill_q   <= fill_up;
					peak_q   <= res.peak;
				end
				batch_q <= req_data.batch_end ? '0 : res.done_count;
			end
			if (cmd.do_start) begin
				run_len_q <= clip_n;
				run_cnt_q <= '0;
			end
			if (cmd.do_word) begin
				rd_ptr_q  <= rd_ptr_nx;
				fill_q    <= fill_dn;
				run_cnt_q <= run_cnt_up;
			end
		end
	end

	// response stage: output register plus one skid entry
	assign emit      = cmd.do_write || cmd.do_empty || cmd.do_word;
	assign pop       = out_v_q && rsp_ready;
	assign out_free  = !out_v_q || pop;
	assign load_out  = out_free && (skid_v_q || emit);
	assign load_skid = emit && !(out_free && !skid_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || emit;
			skid_v_q <= skid_v_q && emit;
		end else if (emit) begin
			skid_v_q <= 1'b1;
		end
	end

	// memory write and registered read into the response stage
	always_ff @(posedge clk) begin
		if (wr_ok) mem[wr_ptr_q] <= WORD_BITS'(req_data.write_word);
		if (load_out) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (cmd.do_word) begin
				out_q <= {WORD_W'(mem[rd_ptr_q]), res[TAIL_W-1:0]};
			end else begin
				out_q <= res;
			end
		end
		if (load_skid) begin
			if (cmd.do_word) skid_q <= {WORD_W'(mem[rd_ptr_q]), res[TAIL_W-1:0]};
			else             skid_q <= res;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp_data  = out_q;

endmodule

// ===== rtl/ring_fifo_with_peak_tracking_top.sv =====
// Ring FIFO with peak tracking: top level.
// Usage:
//   req  - request beats. cmd = write stores write_word if there is room and
//          answers with one beat (valid_res, batch count, occupancy, peak).
//          cmd = read asks for read_count words; the run is clipped to the
//          occupancy and to MAX_BURST and returns one beat per word, the final
//          one flagged last. A run of zero returns one beat with valid_res low.
//   rsp  - result beats, held in an output register with a one-entry skid.
//   cfg  - queue depth write, always ready. A write re-initializes pointers,
//          occupancy, peak and batch count. Write only while the block is idle.
// Timing: a write's result is registered into the response stage. A read
//   first takes the request and clips it, then sends one word per cycle,
//   while the response stage has space, through the single memory read port.
//   The next request is taken after the last word of a run is issued.
// Reset: depth returns to 64 (or DEPTH if smaller), the queue is empty, peak
//   is zero; stored words are not cleared. When rsp stalls, results fill the
//   output and skid registers, then req.ready drops and runs pause.
// Depends on rfpt_pkg, rfpt_ifs, rfpt_ctrl, rfpt_dp.
module ring_fifo_with_peak_tracking_top #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 8,
	parameter int MAX_BURST = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	rfpt_req_if.sink          req,
	rfpt_rsp_if.source        rsp,
	rfpt_cfg_if.sink          cfg
);
	import rfpt_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// depth register is always writable
	assign cfg.ready = 1'b1;

	rfpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.data.cmd),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rfpt_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule
